FILE: rtl/core/lsf_pkg.sv
// Shared constants and types for the least-squares line fit block.
`timescale 1ns / 1ps
package lsf_pkg;

  // Default sizing of the block
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int MAX_POINTS_DEF  = 4096;
  localparam int FRAC_BITS_DEF   = 16;

  // Fit arithmetic wraps at 64 bits
  localparam int ACC_W  = 64;
  localparam int QUOT_W = 32;

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [1:0]       status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_ZERO_DEN = 2'd1;
  localparam status_t STATUS_TOO_MANY = 2'd2;

endpackage

FILE: rtl/core/least_squares_line_fit.sv
// Top level of the least-squares straight-line fit over signed sample pairs.
//
//  channel   direction  handshake            beat
//  sample    in         start & !busy        x_value, y_value, last
//  result    out        done (one cycle)     slope, intercept, point_count, status
//
// A pair is accepted every cycle while busy is low. The pair marked last
// starts the fit: busy is high from the next cycle until done, while the
// bit-serial product unit runs and the shared serial divider makes two passes.
// Sets that end in an error skip the divider.
// rst returns to idle with all sums cleared. The receiver cannot stall.
`timescale 1ns / 1ps
module least_squares_line_fit #(
  parameter int SAMPLE_BITS = lsf_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POINTS  = lsf_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS   = lsf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_BITS-1:0]        x_value,
  input  logic signed [SAMPLE_BITS-1:0]        y_value,
  input  logic                                 last,
  output logic                                 done,
  output logic signed [lsf_pkg::QUOT_W-1:0]    slope,
  output logic signed [lsf_pkg::QUOT_W-1:0]    intercept,
  output logic [$clog2(MAX_POINTS + 1)-1:0]    point_count,
  output lsf_pkg::status_t                     status
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int PR_W  = 2 * SAMPLE_BITS + CNT_W - 1;
  localparam int AW    = lsf_pkg::ACC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVM = 3'd3;
  localparam logic [2:0] ST_DIVB = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic                   accept;
  logic [CNT_W-1:0]       count;
  logic signed [SX_W-1:0] sum_x;
  logic signed [SX_W-1:0] sum_y;
  logic signed [PR_W-1:0] sum_xy;
  logic signed [PR_W-1:0] sum_xx;
  logic                   overflow_seen;
  logic                   ovf_hold;
  lsf_pkg::acc_t          den;
  lsf_pkg::acc_t          num_m;
  lsf_pkg::acc_t          num_b;
  lsf_pkg::acc_t          div_num;
  logic                   mul_done;
  logic                   div_start;
  logic                   div_done;
  logic [lsf_pkg::QUOT_W-1:0] quot;
  logic                   den_bad;

  assign accept  = start && !busy;
  assign busy    = state != ST_IDLE;
  assign done    = state == ST_OUT;
  assign den_bad = den[AW-1] || (den == '0);
  assign div_num = (state == ST_MUL) ? num_m : num_b;

  lsf_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W),
    .SX_W       (SX_W),
    .PR_W       (PR_W)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .add          (accept),
    .clear        (state == ST_LOAD),
    .x_value      (x_value),
    .y_value      (y_value),
    .count        (count),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .sum_xy       (sum_xy),
    .sum_xx       (sum_xx),
    .overflow_seen(overflow_seen)
  );

  lsf_serial_mul #(
    .CNT_W(CNT_W),
    .SX_W (SX_W),
    .PR_W (PR_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .load (state == ST_LOAD),
    .n    (count),
    .sx   (sum_x),
    .sy   (sum_y),
    .sxy  (sum_xy),
    .sxx  (sum_xx),
    .den  (den),
    .num_m(num_m),
    .num_b(num_b),
    .done (mul_done)
  );

  lsf_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (den),
    .quot (quot),
    .done (div_done)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (ovf_hold || den_bad) begin
            state_next = ST_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIVM;
          end
        end
      end
      ST_DIVM: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIVB;
        end
      end
      ST_DIVB: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result beat, built up over the fit
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      point_count <= count;
      ovf_hold    <= overflow_seen;
      slope       <= '0;
      intercept   <= '0;
    end
    if (state == ST_MUL && mul_done) begin
      if (ovf_hold) begin
        status <= lsf_pkg::STATUS_TOO_MANY;
      end else if (den_bad) begin
        status <= lsf_pkg::STATUS_ZERO_DEN;
      end else begin
        status <= lsf_pkg::STATUS_OK;
      end
    end
    if (state == ST_DIVM && div_done) slope <= quot;
    if (state == ST_DIVB && div_done) intercept <= quot;
  end

endmodule

FILE: rtl/core/lsf_accum.sv
// Running count and sums of x, y, x*y and x*x, one sample pair per cycle while add is high.
`timescale 1ns / 1ps
module lsf_accum #(
  parameter int SAMPLE_BITS = lsf_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POINTS  = lsf_pkg::MAX_POINTS_DEF,
  parameter int CNT_W       = $clog2(MAX_POINTS + 1),
  parameter int SX_W        = SAMPLE_BITS + CNT_W,
  parameter int PR_W        = 2 * SAMPLE_BITS + CNT_W - 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          add,
  input  logic                          clear,
  input  logic signed [SAMPLE_BITS-1:0] x_value,
  input  logic signed [SAMPLE_BITS-1:0] y_value,
  output logic        [CNT_W-1:0]       count,
  output logic signed [SX_W-1:0]        sum_x,
  output logic signed [SX_W-1:0]        sum_y,
  output logic signed [PR_W-1:0]        sum_xy,
  output logic signed [PR_W-1:0]        sum_xx,
  output logic                          overflow_seen
);

  logic signed [2*SAMPLE_BITS-1:0] xy;
  logic signed [2*SAMPLE_BITS-1:0] xx;
  logic                            room;

  assign xy   = x_value * y_value;
  assign xx   = x_value * x_value;
  assign room = count < CNT_W'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count         <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xy        <= '0;
      sum_xx        <= '0;
      overflow_seen <= 1'b0;
    end else if (add) begin
      if (room) begin
        count  <= count + 1'b1;
        sum_x  <= sum_x + SX_W'(x_value);
        sum_y  <= sum_y + SX_W'(y_value);
        sum_xy <= sum_xy + PR_W'(xy);
        sum_xx <= sum_xx + PR_W'(xx);
      end else begin
        // pair dropped, set is reported as too many points
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lsf_serial_mul.sv
// Bit-serial forming of the denominator and both numerators, mod 2^64.
`timescale 1ns / 1ps
module lsf_serial_mul #(
  parameter int CNT_W = 13,
  parameter int SX_W  = 25,
  parameter int PR_W  = 36
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [CNT_W-1:0]       n,
  input  logic signed [SX_W-1:0] sx,
  input  logic signed [SX_W-1:0] sy,
  input  logic signed [PR_W-1:0] sxy,
  input  logic signed [PR_W-1:0] sxx,
  output lsf_pkg::acc_t          den,
  output lsf_pkg::acc_t          num_m,
  output lsf_pkg::acc_t          num_b,
  output logic                   done
);

  localparam int AW    = lsf_pkg::ACC_W;
  localparam int STP_W = $clog2(SX_W);

  // multiplier bits, LSB first
  logic [SX_W-1:0]  mn;
  logic [SX_W-1:0]  mx;
  logic [SX_W-1:0]  my;
  // multiplicands, shifted left one place per step
  lsf_pkg::acc_t    a_xx;
  lsf_pkg::acc_t    a_xy;
  lsf_pkg::acc_t    a_x;
  lsf_pkg::acc_t    a_y;
  logic [STP_W-1:0] step;
  logic             run;
  logic             top_bit;
  lsf_pkg::acc_t    d_den;
  lsf_pkg::acc_t    d_m;
  lsf_pkg::acc_t    d_b;

  assign top_bit = step == STP_W'(SX_W - 1);

  // den = n*Sxx - Sx*Sx, num_m = n*Sxy - Sx*Sy, num_b = Sy*Sxx - Sx*Sxy
  always_comb begin
    d_den = (mn[0] ? a_xx : '0) - (mx[0] ? a_x  : '0);
    d_m   = (mn[0] ? a_xy : '0) - (mx[0] ? a_y  : '0);
    d_b   = (my[0] ? a_xx : '0) - (mx[0] ? a_xy : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
      end else if (run && top_bit) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mn    <= SX_W'(n);
      mx    <= sx;
      my    <= sy;
      a_xx  <= AW'(sxx);
      a_xy  <= AW'(sxy);
      a_x   <= AW'(sx);
      a_y   <= AW'(sy);
      step  <= '0;
      den   <= '0;
      num_m <= '0;
      num_b <= '0;
    end else if (run) begin
      mn   <= mn >> 1;
      mx   <= mx >> 1;
      my   <= my >> 1;
      a_xx <= a_xx << 1;
      a_xy <= a_xy << 1;
      a_x  <= a_x << 1;
      a_y  <= a_y << 1;
      step <= step + 1'b1;
      // sign bit of a two's complement multiplier carries negative weight
      if (top_bit) begin
        den   <= den - d_den;
        num_m <= num_m - d_m;
        num_b <= num_b - d_b;
      end else begin
        den   <= den + d_den;
        num_m <= num_m + d_m;
        num_b <= num_b + d_b;
      end
    end
  end

endmodule

FILE: rtl/core/lsf_divider.sv
// Restoring bit-serial divider giving a saturated signed fixed-point quotient.
`timescale 1ns / 1ps
module lsf_divider #(
  parameter int FRAC_BITS = lsf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lsf_pkg::acc_t                 num,
  input  lsf_pkg::acc_t                 den,
  output logic [lsf_pkg::QUOT_W-1:0]    quot,
  output logic                          done
);

  localparam int AW    = lsf_pkg::ACC_W;
  localparam int QW    = lsf_pkg::QUOT_W;
  localparam int DV_W  = AW + FRAC_BITS;
  localparam int STP_W = $clog2(DV_W);
  localparam logic [QW:0] POS_MAX = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] NEG_MAX = {2'b01, {(QW-1){1'b0}}};

  logic [DV_W-1:0]  dv;
  lsf_pkg::acc_t    dvsr;
  lsf_pkg::acc_t    rem;
  lsf_pkg::acc_t    trial;
  lsf_pkg::acc_t    mag;
  logic [QW:0]      q;
  logic             over;
  logic             neg;
  logic             qbit;
  logic             run;
  logic [STP_W-1:0] step;

  assign mag   = num[AW-1] ? (~num + 1'b1) : num;
  // remainder stays below the positive divisor, so its top bit is clear
  assign trial = {rem[AW-2:0], dv[DV_W-1]};
  assign qbit  = trial >= dvsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && step == STP_W'(DV_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv   <= DV_W'(mag) << FRAC_BITS;
      dvsr <= den;
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      neg  <= num[AW-1];
      step <= '0;
    end else if (run) begin
      dv   <= dv << 1;
      rem  <= qbit ? (trial - dvsr) : trial;
      q    <= {q[QW-1:0], qbit};
      over <= over | q[QW];
      step <= step + 1'b1;
    end
  end

  always_comb begin
    if (!neg) begin
      quot = (over || q > POS_MAX) ? POS_MAX[QW-1:0] : q[QW-1:0];
    end else if (over || q > NEG_MAX) begin
      quot = NEG_MAX[QW-1:0];
    end else begin
      quot = ~q[QW-1:0] + 1'b1;
    end
  end

endmodule
